### rtl/planar_bitmap_to_argb_core_defines.svh
// Assertion macros used by the checker file of the planar bitmap core.
`ifndef PLANAR_BITMAP_TO_ARGB_CORE_DEFINES_SVH
`define PLANAR_BITMAP_TO_ARGB_CORE_DEFINES_SVH

// Overlapping implication, checked on the rising clock edge outside reset.
`define PBTA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("planar bitmap core assertion failed");

// Non-overlapping implication, checked in the cycle after the antecedent.
`define PBTA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("planar bitmap core assertion failed");

`endif

### rtl/pbta_pkg.sv
// Package with the payload types, codes and palette of the planar bitmap core.
`default_nettype none
package pbta_pkg;

   // Action codes of an input transaction.
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_READ  = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_PLANE_COUNT  = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [7:0] RESET_IMAGE_WIDTH  = 8'd16;
   localparam logic [7:0] RESET_IMAGE_HEIGHT = 8'd16;
   localparam logic [3:0] RESET_PLANE_COUNT  = 4'd2;

   // Fixed ARGB palette selected by the low three bits of the color index.
   localparam logic [31:0] PALETTE [8] = '{
      32'hFFAAAAAA, 32'hFF000000, 32'hFFFFFFFF, 32'hFF6666BB,
      32'hFF999999, 32'hFFBBBBBB, 32'hFFBBAA99, 32'hFFFFAA22
   };

   typedef struct packed {
      logic       action;
      logic [2:0] plane_index;
      logic [6:0] row_index;
      logic [3:0] byte_column;
      logic [7:0] data_byte;
      logic [6:0] pixel_x;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_argb;
      logic        out_of_range;
   } rsp_type;

   // Classified transaction handed from the front end to the back end.
   typedef struct packed {
      logic       is_read;
      logic       out_of_range;
      logic       write_en;
      logic [2:0] plane;
      logic [7:0] data;
      logic [2:0] bit_sel;
      logic [3:0] plane_cnt;
   } item_ctl_type;

endpackage
`default_nettype wire

### rtl/pbta_queue.sv
// Short first-in first-out queue between the front end and the back end.
`default_nettype none
module pbta_queue import pbta_pkg::*; #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates, with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### rtl/pbta_front.sv
// Front end: configuration registers, transaction acceptance and classification.
`default_nettype none
module pbta_front import pbta_pkg::*; #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128,
   parameter int MAX_PLANES = 8,
   parameter int ADDR_W     = 11
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire req_type     req_data,
   input  wire logic        queue_full,
   output logic             push,
   output item_ctl_type     push_ctl,
   output logic [ADDR_W-1:0] push_addr,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   localparam int ROW_SLOTS = ((MAX_WIDTH + 15) / 16) * 2;

   logic [7:0] width_ff, height_ff;
   logic [3:0] planes_ff;
   logic [7:0] width_eff, height_eff;
   logic [3:0] planes_eff;
   logic [5:0] row_len;
   logic       is_read, read_in_range, write_ok;
   logic [3:0] col_sel;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_IMAGE_WIDTH;
         height_ff <= RESET_IMAGE_HEIGHT;
         planes_ff <= RESET_PLANE_COUNT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            CSR_PLANE_COUNT:  planes_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Saturate the registers at the storage limits.
   always_comb begin
      width_eff  = (32'(width_ff) > MAX_WIDTH) ? 8'(MAX_WIDTH) : width_ff;
      height_eff = (32'(height_ff) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : height_ff;
      planes_eff = (32'(planes_ff) > MAX_PLANES) ? 4'(MAX_PLANES) : planes_ff;
      row_len    = 6'(((9'(width_eff) + 9'd15) >> 4) << 1);
   end

   // Classify the transaction and form its bank address.
   always_comb begin
      is_read       = (req_data.action == ACT_READ);
      read_in_range = (8'(req_data.pixel_x) < width_eff) &&
                      (8'(req_data.row_index) < height_eff);
      write_ok      = (32'(req_data.plane_index) < MAX_PLANES) &&
                      (8'(req_data.row_index) < height_eff) &&
                      (6'(req_data.byte_column) < row_len);
      col_sel       = is_read ? req_data.pixel_x[6:3] : req_data.byte_column;

      push_ctl.is_read      = is_read;
      push_ctl.out_of_range = is_read && !read_in_range;
      push_ctl.write_en     = !is_read && write_ok;
      push_ctl.plane        = req_data.plane_index;
      push_ctl.data         = req_data.data_byte;
      push_ctl.bit_sel      = req_data.pixel_x[2:0];
      push_ctl.plane_cnt    = planes_eff;
      push_addr = ADDR_W'(32'(req_data.row_index) * ROW_SLOTS + 32'(col_sel));
   end

   assign push = start && !queue_full;

endmodule
`default_nettype wire

### rtl/pbta_back.sv
// Back end: per-plane byte banks, bit gathering and palette lookup.
`default_nettype none
module pbta_back import pbta_pkg::*; #(
   parameter int MAX_PLANES = 8,
   parameter int ADDR_W     = 11,
   parameter int DEPTH      = 2048
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  wire item_ctl_type      item_ctl,
   input  wire logic [ADDR_W-1:0] item_addr,
   output logic                   pop,
   output logic                   rsp_valid,
   output rsp_type                rsp_data
);

   logic [7:0] rd_byte_ff [MAX_PLANES];
   logic       s1_valid_ff, s1_oor_ff;
   logic [2:0] s1_bit_ff;
   logic [3:0] s1_cnt_ff;
   logic [7:0] color_index;
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff, rsp_data_in;

   // The back end never stalls, so it takes an entry whenever one waits.
   assign pop = item_valid;

   // One byte bank per plane, written by its own plane and read by every read.
   for (genvar p = 0; p < MAX_PLANES; p++) begin : g_bank
      logic [7:0] bank_ff [DEPTH];

      always_ff @(posedge clock) begin
         if (pop && item_ctl.write_en && (item_ctl.plane == 3'(p))) begin
            bank_ff[item_addr] <= item_ctl.data;
         end
         if (pop && item_ctl.is_read) begin
            rd_byte_ff[p] <= bank_ff[item_addr];
         end
      end
   end

   // Read stage control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= pop && item_ctl.is_read;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && item_ctl.is_read) begin
         s1_oor_ff <= item_ctl.out_of_range;
         s1_bit_ff <= item_ctl.bit_sel;
         s1_cnt_ff <= item_ctl.plane_cnt;
      end
   end

   // Gather one bit per enabled plane, leftmost pixel in bit 7.
   always_comb begin
      color_index = '0;
      for (int p = 0; p < MAX_PLANES; p++) begin
         color_index[p] = rd_byte_ff[p][~s1_bit_ff] && (4'(p) < s1_cnt_ff);
      end
      if (s1_oor_ff) begin
         rsp_data_in.pixel_argb   = '0;
         rsp_data_in.out_of_range = 1'b1;
      end else begin
         rsp_data_in.pixel_argb   = PALETTE[color_index[2:0]];
         rsp_data_in.out_of_range = 1'b0;
      end
   end

   // Result register, one strobe per read transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

### rtl/planar_bitmap_to_argb_core.sv
// A read goes from the queue to the bank read registers, then to the result register.
// Throughput: one transaction per cycle; the back end drains the queue every cycle,
// so busy rises only if the two-entry queue between front and back end is full.
// Writes produce no result and go through the bank write port of their plane.
// Synchronous reset clears the pipeline, the queue and the registers (16, 16, 2);
// the plane banks are not cleared and hold undefined data until written.
`default_nettype none
module planar_bitmap_to_argb_core import pbta_pkg::*; #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128,
   parameter int MAX_PLANES = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   output rsp_type         rsp_data,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata
);

   localparam int ROW_SLOTS = ((MAX_WIDTH + 15) / 16) * 2;
   localparam int DEPTH     = MAX_HEIGHT * ROW_SLOTS;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int CTL_W     = $bits(item_ctl_type);
   localparam int ITEM_W    = CTL_W + ADDR_W;

   logic              push, queue_full, pop, queue_valid;
   item_ctl_type      push_ctl, pop_ctl;
   logic [ADDR_W-1:0] push_addr, pop_addr;
   logic [ITEM_W-1:0] pop_item;

   assign busy = queue_full;

   pbta_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .MAX_PLANES(MAX_PLANES),
      .ADDR_W    (ADDR_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .queue_full(queue_full),
      .push      (push),
      .push_ctl  (push_ctl),
      .push_addr (push_addr),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pbta_queue #(
      .WIDTH(ITEM_W),
      .DEPTH(2)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data({push_ctl, push_addr}),
      .full     (queue_full),
      .pop      (pop),
      .pop_data (pop_item),
      .not_empty(queue_valid)
   );

   // Split the queue entry back into control and address.
   assign pop_ctl  = item_ctl_type'(pop_item[ITEM_W-1 -: CTL_W]);
   assign pop_addr = pop_item[ADDR_W-1:0];

   pbta_back #(
      .MAX_PLANES(MAX_PLANES),
      .ADDR_W    (ADDR_W),
      .DEPTH     (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .item_valid(queue_valid),
      .item_ctl  (pop_ctl),
      .item_addr (pop_addr),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

### rtl/pbta_checker.sv
// Port-level checker for the planar bitmap core and its bind statement.
`default_nettype none
`include "planar_bitmap_to_argb_core_defines.svh"
module pbta_checker import pbta_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);

   logic accept_read, accept_write;

   // Accepted read and write transactions at the input port.
   assign accept_read  = start && !busy && (req_data.action == ACT_READ);
   assign accept_write = start && !busy && (req_data.action == ACT_WRITE);

   // Every accepted read yields a result strobe at the end of the pipeline.
   `PBTA_ASSERT_IMPL(a_read_gives_result, clock, reset, accept_read, ##3 rsp_valid)

   // A write transaction never produces a result.
   `PBTA_ASSERT_IMPL(a_write_no_result, clock, reset, accept_write, ##3 !rsp_valid)

   // No result strobe appears without a matching earlier accepted read.
   `PBTA_ASSERT_IMPL(a_no_spurious_result, clock, reset, rsp_valid, $past(accept_read, 3))

   // An out-of-range result carries a zero color.
   `PBTA_ASSERT_IMPL(a_oor_zero, clock, reset, rsp_valid && rsp_data.out_of_range, rsp_data.pixel_argb == 32'd0)

endmodule

bind planar_bitmap_to_argb_core pbta_checker u_checker (.*);
`default_nettype wire

### bench/tb_top.sv
// Self-checking testbench that drives the planar bitmap core and checks every pixel read.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pbta_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 170;
   localparam int PHASES        = 8;
   localparam int DIRECTED_ROWS = 22;
   localparam int MAX_W         = 128;
   localparam int MAX_H         = 128;
   localparam int MAX_P         = 8;

   // Register settings and sender idle rate of each random phase.
   localparam logic [7:0] PHASE_WIDTH  [PHASES] = '{16, 128, 1, 255, 0, 77, 40, 100};
   localparam logic [7:0] PHASE_HEIGHT [PHASES] = '{16, 128, 1, 255, 37, 0, 100, 128};
   localparam logic [3:0] PHASE_PLANES [PHASES] = '{2, 8, 1, 15, 3, 0, 0, 5};
   localparam int         PHASE_IDLE   [PHASES] = '{0, 59, 0, 33, 0, 59, 0, 33};

   localparam rsp_type OFF_IMAGE = '{pixel_argb: 32'h0, out_of_range: 1'b1};
   localparam rsp_type NOT_TYPED = '0;

   typedef struct packed {
      req_type item;
      bit      typed;
      rsp_type pixel;
   } directed_row_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_data;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   // Shadow copy of the plane banks and of the registers.
   logic [7:0] plane_bytes  [MAX_P][MAX_H][16];
   bit         byte_written [MAX_P][MAX_H][16];
   logic [7:0] cfg_width;
   logic [7:0] cfg_height;
   logic [3:0] cfg_planes;

   rsp_type          pending_pixels [$];
   directed_row_type directed_rows [DIRECTED_ROWS];
   int               error_count;
   int               cycle_count;

   planar_bitmap_to_argb_core uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // Width, height and plane count as the core uses them, after saturation.
   function automatic int active_width();
      return (int'(cfg_width) > MAX_W) ? MAX_W : int'(cfg_width);
   endfunction

   function automatic int active_height();
      return (int'(cfg_height) > MAX_H) ? MAX_H : int'(cfg_height);
   endfunction

   function automatic int active_planes();
      return (int'(cfg_planes) > MAX_P) ? MAX_P : int'(cfg_planes);
   endfunction

   function automatic int padded_row_len();
      return ((active_width() + 15) / 16) * 2;
   endfunction

   // Lowest plane whose byte a read would fetch without it ever being written, or -1.
   function automatic int missing_plane(input req_type item);
      int col;
      if (item.action != ACT_READ || int'(item.pixel_x) >= active_width()
          || int'(item.row_index) >= active_height())
         return -1;
      col = int'(item.pixel_x) / 8;
      for (int p = 0; p < active_planes(); p++)
         if (!byte_written[p][item.row_index][col]) return p;
      return -1;
   endfunction

   function automatic req_type noise_item();
      req_type item;
      item.action      = 1'($urandom);
      item.plane_index = 3'($urandom);
      item.row_index   = 7'($urandom);
      item.byte_column = 4'($urandom);
      item.data_byte   = 8'($urandom);
      item.pixel_x     = 7'($urandom);
      return item;
   endfunction

   // Unused fields of a transaction carry random values.
   function automatic req_type read_item(input int x, input int y);
      req_type item;
      item           = noise_item();
      item.action    = ACT_READ;
      item.pixel_x   = 7'(x);
      item.row_index = 7'(y);
      return item;
   endfunction

   function automatic req_type write_item(input int plane, input int row, input int col,
                                          input logic [7:0] value);
      req_type item;
      item             = noise_item();
      item.action      = ACT_WRITE;
      item.plane_index = 3'(plane);
      item.row_index   = 7'(row);
      item.byte_column = 4'(col);
      item.data_byte   = value;
      return item;
   endfunction

   // A read that would touch a never-written byte becomes the write of that byte.
   function automatic req_type guard_read(input req_type item);
      req_type safe;
      int      plane;
      safe  = item;
      plane = missing_plane(item);
      if (plane >= 0) begin
         safe.action      = ACT_WRITE;
         safe.plane_index = 3'(plane);
         safe.byte_column = 4'(int'(item.pixel_x) / 8);
      end
      return safe;
   endfunction

   // Applies one transaction to the shadow image and works out the pixel it returns.
   task automatic predict_argb(input req_type item, output bit has_pixel,
                               output rsp_type pixel, output bit counted);
      logic [7:0] color_index;
      int         col;
      has_pixel   = 1'b0;
      counted     = 1'b0;
      pixel       = '0;
      color_index = '0;
      col         = int'(item.pixel_x) / 8;
      if (item.action == ACT_WRITE) begin
         counted = 1'b1;
         if (int'(item.row_index) < active_height() &&
             int'(item.byte_column) < padded_row_len()) begin
            plane_bytes[item.plane_index][item.row_index][item.byte_column] = item.data_byte;
            byte_written[item.plane_index][item.row_index][item.byte_column] = 1'b1;
         end
      end else begin
         has_pixel = 1'b1;
         counted   = 1'b1;
         if (int'(item.pixel_x) >= active_width() || int'(item.row_index) >= active_height()) begin
            pixel = OFF_IMAGE;
         end else begin
            for (int p = 0; p < active_planes(); p++)
               color_index[p] = plane_bytes[p][item.row_index][col][3'd7 - item.pixel_x[2:0]];
            pixel = '{pixel_argb: PALETTE[color_index[2:0]], out_of_range: 1'b0};
         end
      end
   endtask

   // Presents one transaction and holds it until the core takes it.
   task automatic send_item(input req_type item, input bit typed, input rsp_type typed_pixel,
                            output bit counted);
      bit      has_pixel;
      rsp_type pixel;
      @(negedge clock);
      start    <= 1'b1;
      req_data <= item;
      do begin
         @(posedge clock);
      end while (busy !== 1'b0);
      predict_argb(item, has_pixel, pixel, counted);
      if (has_pixel) pending_pixels.push_back(typed ? typed_pixel : pixel);
   endtask

   // Random idle cycles on the request side; each further idle cycle follows with a chance of pct percent.
   task automatic idle_gap(input int pct);
      while (int'($urandom_range(99, 0)) < pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // Stops sending and waits until every pixel has come back and the core is quiet.
   task automatic drain_pixels();
      @(negedge clock);
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do begin
         @(posedge clock);
      end while (csr_ready !== 1'b1);
      case (index)
         CSR_IMAGE_WIDTH: cfg_width = value;
         CSR_IMAGE_HEIGHT: cfg_height = value;
         CSR_PLANE_COUNT: cfg_planes = value[3:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One random phase: sets the registers, then mostly byte fills followed by reads of those pixels, some noise.
   task automatic run_phase(input int phase);
      int counted_items;
      bit counted;
      bit midway_done;
      int row;
      int col;
      int planes;
      int pct;
      drain_pixels();
      csr_write(CSR_IMAGE_WIDTH, PHASE_WIDTH[phase]);
      csr_write(CSR_IMAGE_HEIGHT, PHASE_HEIGHT[phase]);
      csr_write(CSR_PLANE_COUNT, PHASE_PLANES[phase]);
      pct           = PHASE_IDLE[phase];
      counted_items = 0;
      midway_done   = 1'b0;
      while (counted_items < PHASE_ITEMS) begin
         if (!midway_done && counted_items >= PHASE_ITEMS / 2) begin
            drain_pixels();
            midway_done = 1'b1;
         end
         if (active_width() > 0 && active_height() > 0 && $urandom_range(99, 0) < 70) begin
            row    = $urandom_range(active_height() - 1, 0);
            col    = $urandom_range((active_width() - 1) / 8, 0);
            planes = (active_planes() == 0) ? 1 : active_planes();
            if ($urandom_range(3, 0) != 0) begin
               for (int p = 0; p < planes; p++) begin
                  idle_gap(pct);
                  send_item(write_item(p, row, col, 8'($urandom)), 1'b0, NOT_TYPED, counted);
                  counted_items += counted;
               end
            end
            repeat ($urandom_range(4, 1)) begin
               idle_gap(pct);
               send_item(guard_read(read_item(col * 8 + $urandom_range(7, 0), row)),
                         1'b0, NOT_TYPED, counted);
               counted_items += counted;
            end
         end else begin
            idle_gap(pct);
            send_item(guard_read(noise_item()), 1'b0, NOT_TYPED, counted);
            counted_items += counted;
         end
      end
   endtask

   // Compare each pixel result with the oldest one expected.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected pixel result: pixel_argb %h out_of_range %b",
                   rsp_data.pixel_argb, rsp_data.out_of_range);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_data.pixel_argb !== want.pixel_argb) begin
               $error("pixel_argb: expected %h, actual %h", want.pixel_argb, rsp_data.pixel_argb);
               error_count++;
            end
            if (rsp_data.out_of_range !== want.out_of_range) begin
               $error("out_of_range: expected %b, actual %b",
                      want.out_of_range, rsp_data.out_of_range);
               error_count++;
            end
         end
      end
   end

   // Watchdog on the total run length.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      bit counted;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_valid   = 1'b0;
      csr_index   = CSR_IMAGE_WIDTH;
      csr_wdata   = '0;
      cfg_width   = RESET_IMAGE_WIDTH;
      cfg_height  = RESET_IMAGE_HEIGHT;
      cfg_planes  = RESET_PLANE_COUNT;
      error_count = 0;
      foreach (byte_written[p, r, c]) byte_written[p][r][c] = 1'b0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed transactions under the reset settings of 16 by 16 pixels and two planes.
      directed_rows = '{
         '{read_item(16, 0), 1'b1, OFF_IMAGE},
         '{read_item(0, 16), 1'b1, OFF_IMAGE},
         '{read_item(127, 127), 1'b1, OFF_IMAGE},
         '{write_item(0, 0, 0, 8'hFF), 1'b0, NOT_TYPED},
         '{write_item(1, 0, 0, 8'h00), 1'b0, NOT_TYPED},
         '{read_item(0, 0), 1'b1, rsp_type'{32'hFF000000, 1'b0}},
         '{read_item(7, 0), 1'b1, rsp_type'{32'hFF000000, 1'b0}},
         '{write_item(1, 0, 0, 8'hFF), 1'b0, NOT_TYPED},
         '{read_item(3, 0), 1'b1, rsp_type'{32'hFF6666BB, 1'b0}},
         '{write_item(0, 15, 1, 8'h01), 1'b0, NOT_TYPED},
         '{write_item(1, 15, 1, 8'h80), 1'b0, NOT_TYPED},
         '{read_item(8, 15), 1'b0, NOT_TYPED},
         '{read_item(15, 15), 1'b0, NOT_TYPED},
         '{read_item(12, 15), 1'b0, NOT_TYPED},
         // Writes past the last row or the padded row are dropped.
         '{write_item(0, 16, 0, 8'hAA), 1'b0, NOT_TYPED},
         '{write_item(1, 0, 2, 8'h55), 1'b0, NOT_TYPED},
         // A plane above the plane count is still stored if its row and column are in range.
         '{write_item(7, 0, 0, 8'h5A), 1'b0, NOT_TYPED},
         '{write_item(7, 127, 15, 8'hFF), 1'b0, NOT_TYPED},
         '{write_item(0, 0, 1, 8'h00), 1'b0, NOT_TYPED},
         '{write_item(1, 0, 1, 8'h3C), 1'b0, NOT_TYPED},
         '{read_item(10, 0), 1'b0, NOT_TYPED},
         '{read_item(15, 0), 1'b0, NOT_TYPED}
      };
      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].pixel, counted);

      for (int phase = 0; phase < PHASES; phase++) run_phase(phase);

      drain_pixels();
      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
